/* rtl/bvcs_pkg.sv */
// Package for the base velocity command shaper.
// Fixed-point constants, sequencer state type and datapath widths.
// No dependencies.
package bvcs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 22;
    localparam int DW        = 48;
    localparam int MW        = 24;

    localparam logic [DW-1:0] ONE_Q      = 48'd1 << FRAC_BITS;
    localparam logic [DW-1:0] C_LIN      = 48'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);
    localparam logic [DW-1:0] C_ANG      = 48'(((64'd1 << FRAC_BITS) + 64'd2) / 64'd4);
    localparam logic [DW-1:0] C_ARRIVE   = 48'(((64'd1 << FRAC_BITS) + 64'd25) / 64'd50);
    localparam logic [DW-1:0] C_APPROACH = 48'(((64'd1 << FRAC_BITS) + 64'd4) / 64'd8);
    localparam logic [DW-1:0] C_DMAX     = 48'd5 << FRAC_BITS;
    localparam logic [DW-1:0] C_LIN_LIM  = 48'(((64'd51 << FRAC_BITS) + 64'd100) / 64'd200);
    localparam logic [DW-1:0] C_ANG_LIM  = 48'(((64'd13 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [DW-1:0] C_STALL    = 48'(((64'd1 << FRAC_BITS) + 64'd100) / 64'd200);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIVX, ST_DIVY, ST_DIVW, ST_MX, ST_MY, ST_MW, ST_SQ1, ST_SQ2,
        ST_SQRT, ST_BASE, ST_B2, ST_B3, ST_DX, ST_DY, ST_DW, ST_OUT
    } state_t;

endpackage

/* rtl/bvcs_div.sv */
// Restoring divider, one quotient bit per cycle.
// Uses bvcs_pkg.
module bvcs_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [bvcs_pkg::DW-1:0] num,
    input  logic [bvcs_pkg::DW-1:0] den,
    output logic [bvcs_pkg::DW-1:0] quo,
    output logic                   busy
);
    logic [bvcs_pkg::DW-1:0] rem_reg, rem_next, quo_reg, quo_next, den_reg;
    logic [5:0]              cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic [bvcs_pkg::DW:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[bvcs_pkg::DW-1]} - {1'b0, den_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = 6'(bvcs_pkg::DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[bvcs_pkg::DW]) begin
                rem_next = trial[bvcs_pkg::DW-1:0];
                quo_next = {quo_reg[bvcs_pkg::DW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[bvcs_pkg::DW-2:0], quo_reg[bvcs_pkg::DW-1]};
                quo_next = {quo_reg[bvcs_pkg::DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) den_reg <= den;
    end

    assign quo  = quo_reg;
    assign busy = busy_reg;
endmodule

/* rtl/bvcs_sqrt.sv */
// Bitwise integer square root, one result bit per cycle.
// Uses bvcs_pkg.
module bvcs_sqrt (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [bvcs_pkg::DW-1:0] val,
    output logic [bvcs_pkg::DW-1:0] root,
    output logic                   busy
);
    logic [bvcs_pkg::DW-1:0] v_reg, v_next, r_reg, r_next, b_reg, b_next;
    logic                    busy_reg, busy_next;
    logic [bvcs_pkg::DW-1:0] rb;

    always_comb begin
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        rb        = r_reg + b_reg;
        if (start) begin
            v_next    = val;
            r_next    = '0;
            b_next    = 48'd1 << (bvcs_pkg::DW - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= rb) begin
                v_next = v_reg - rb;
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            if (b_reg[0]) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign root = r_reg;
    assign busy = busy_reg;
endmodule

/* rtl/base_velocity_command_shaper.sv */
// Base velocity command shaper top: sequencer, shared 24x24 multiplier, divider, root.
// Uses bvcs_pkg, bvcs_div, bvcs_sqrt.
// Accept to m_tvalid: a scale divide per axis unless skipped, the root, then the approach
// gain unless skipped. s_tready stays low until the result beat is taken, so beats do not
// overlap. Synchronous active-low reset clears counters, sequencer; sets exit_when_stuck.
module base_velocity_command_shaper (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // target_dx, target_dy, heading_error, travelled, moved
    input  logic         s_tuser,  // new_goal
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // vel_x, vel_y, vel_turn, send, arrived, stuck, failed
);
    localparam int DW = bvcs_pkg::DW;
    localparam int MW = bvcs_pkg::MW;

    bvcs_pkg::state_t state_reg, state_next;
    logic ews_reg;
    logic [3:0] tick_reg, tick_next, stall_reg, stall_next;
    logic nx_reg, ny_reg, nw_reg;
    logic [DW-1:0] mx_reg, my_reg, mw_reg, s_reg, sw_reg, t_reg, b_reg, d_reg, trav_reg;
    logic [DW-1:0] vx_reg, vy_reg, vw_reg, dist_reg;
    logic [20:0] moved_reg;
    logic pend_reg;
    logic m_valid_reg;
    logic [71:0] m_data_reg;

    logic [MW-1:0] ma, mb;
    logic [2*MW-1:0] mfull;
    logic [DW-1:0] mprod;
    logic div_start, div_busy;
    logic [DW-1:0] dnum, dden, dquo;
    logic sq_start, sq_busy;
    logic [DW-1:0] sq_root;
    logic [DW-1:0] ax, thr, used;
    logic accept, no_div;
    logic [71:0] cand_data;
    logic st_stuck;

    assign mfull = ma * mb;
    assign mprod = DW'(mfull >> bvcs_pkg::FRAC_BITS);

    bvcs_div u_div (.aclk, .aresetn, .start(div_start), .num(dnum), .den(dden),
                    .quo(dquo), .busy(div_busy));
    bvcs_sqrt u_sqrt (.aclk, .aresetn, .start(sq_start), .val(t_reg), .root(sq_root),
                      .busy(sq_busy));

    function automatic logic [21:0] enc(input logic neg, input logic [DW-1:0] m);
        logic [DW-1:0] lim;
        lim = DW'(1) << (bvcs_pkg::OUT_W - 1);
        if (neg) begin
            if (m > lim) return 22'(-lim);
            return 22'(-m);
        end
        if (m > lim - 1) return 22'(lim - 1);
        return 22'(m);
    endfunction

    assign s_tready = (state_reg == bvcs_pkg::ST_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        case (state_reg)
            bvcs_pkg::ST_DIVY: ax = my_reg;
            bvcs_pkg::ST_DIVW: ax = mw_reg;
            default:           ax = mx_reg;
        endcase
        thr = (state_reg == bvcs_pkg::ST_DIVW) ? bvcs_pkg::C_ANG : bvcs_pkg::C_LIN;
    end

    assign no_div = (ax <= thr);
    assign used   = (dist_reg < trav_reg) ? dist_reg : trav_reg;

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        dnum       = thr << bvcs_pkg::FRAC_BITS;
        dden       = ax;
        ma         = '0;
        mb         = '0;
        case (state_reg)
            bvcs_pkg::ST_IDLE: if (accept) state_next = bvcs_pkg::ST_DIVX;
            bvcs_pkg::ST_DIVX, bvcs_pkg::ST_DIVY, bvcs_pkg::ST_DIVW: begin
                if (no_div || (pend_reg && !div_busy))
                    state_next = (state_reg == bvcs_pkg::ST_DIVX) ? bvcs_pkg::ST_DIVY :
                                 (state_reg == bvcs_pkg::ST_DIVY) ? bvcs_pkg::ST_DIVW :
                                                                    bvcs_pkg::ST_MX;
                else if (!pend_reg)
                    div_start = 1'b1;
            end
            bvcs_pkg::ST_MX: begin
                ma = mx_reg[MW-1:0];
                mb = s_reg[MW-1:0];
                state_next = bvcs_pkg::ST_MY;
            end
            bvcs_pkg::ST_MY: begin
                ma = my_reg[MW-1:0];
                mb = s_reg[MW-1:0];
                state_next = bvcs_pkg::ST_MW;
            end
            bvcs_pkg::ST_MW: begin
                ma = mw_reg[MW-1:0];
                mb = s_reg[MW-1:0];
                state_next = bvcs_pkg::ST_SQ1;
            end
            bvcs_pkg::ST_SQ1: begin
                ma = mx_reg[MW-1:0];
                mb = mx_reg[MW-1:0];
                state_next = bvcs_pkg::ST_SQ2;
            end
            bvcs_pkg::ST_SQ2: begin
                ma = my_reg[MW-1:0];
                mb = my_reg[MW-1:0];
                state_next = bvcs_pkg::ST_SQRT;
            end
            bvcs_pkg::ST_SQRT: begin
                if (!pend_reg) sq_start = 1'b1;
                else if (!sq_busy) state_next = bvcs_pkg::ST_BASE;
            end
            bvcs_pkg::ST_BASE: state_next = (used > bvcs_pkg::C_APPROACH) ? bvcs_pkg::ST_B2
                                                                          : bvcs_pkg::ST_OUT;
            bvcs_pkg::ST_B2: begin
                ma = b_reg[MW-1:0];
                mb = b_reg[MW-1:0];
                state_next = bvcs_pkg::ST_B3;
            end
            bvcs_pkg::ST_B3: begin
                // operand is truncated only when the square already exceeds the clamp
                ma = d_reg[MW-1:0];
                mb = b_reg[MW-1:0];
                state_next = bvcs_pkg::ST_DX;
            end
            bvcs_pkg::ST_DX: begin
                ma = vx_reg[MW-1:0];
                mb = d_reg[MW-1:0];
                state_next = bvcs_pkg::ST_DY;
            end
            bvcs_pkg::ST_DY: begin
                ma = vy_reg[MW-1:0];
                mb = d_reg[MW-1:0];
                state_next = bvcs_pkg::ST_DW;
            end
            bvcs_pkg::ST_DW: begin
                ma = vw_reg[MW-1:0];
                mb = d_reg[MW-1:0];
                state_next = bvcs_pkg::ST_OUT;
            end
            bvcs_pkg::ST_OUT: state_next = bvcs_pkg::ST_IDLE;
            default: state_next = bvcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bvcs_pkg::ST_IDLE;
            ews_reg     <= 1'b1;
            tick_reg    <= '0;
            stall_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) ews_reg <= cfg_wr_data;
            if (accept && s_tuser) begin
                tick_reg  <= '0;
                stall_reg <= '0;
            end
            if (state_reg == bvcs_pkg::ST_OUT) begin
                tick_reg    <= tick_next;
                stall_reg   <= stall_next;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (div_start || sq_start) pend_reg <= 1'b1;
            else if (state_next != state_reg) pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            bvcs_pkg::ST_IDLE: if (accept) begin
                mx_reg <= DW'(s_tdata[21] ? -{{26{s_tdata[21]}}, s_tdata[21:0]}
                                          : {26'd0, s_tdata[21:0]});
                my_reg <= DW'(s_tdata[43] ? -{{26{s_tdata[43]}}, s_tdata[43:22]}
                                          : {26'd0, s_tdata[43:22]});
                mw_reg <= DW'(s_tdata[62] ? -{{29{s_tdata[62]}}, s_tdata[62:44]}
                                          : {29'd0, s_tdata[62:44]});
                nx_reg <= s_tdata[21];
                ny_reg <= s_tdata[43];
                nw_reg <= s_tdata[62];
                trav_reg <= ({27'd0, s_tdata[83:63]} << 1) + {27'd0, s_tdata[83:63]};
                moved_reg <= s_tdata[104:84];
                s_reg <= bvcs_pkg::ONE_Q;
            end
            bvcs_pkg::ST_DIVX, bvcs_pkg::ST_DIVY, bvcs_pkg::ST_DIVW: begin
                if (no_div) begin
                    if (state_reg == bvcs_pkg::ST_DIVW) sw_reg <= bvcs_pkg::ONE_Q;
                end else if (pend_reg && !div_busy) begin
                    if (dquo < s_reg) s_reg <= dquo;
                    if (state_reg == bvcs_pkg::ST_DIVW) sw_reg <= dquo;
                end
            end
            bvcs_pkg::ST_MX: vx_reg <= mprod;
            bvcs_pkg::ST_MY: vy_reg <= mprod;
            bvcs_pkg::ST_MW: begin
                if (s_reg == sw_reg && mw_reg < bvcs_pkg::C_LIN)
                    vw_reg <= (mw_reg == '0) ? '0 : bvcs_pkg::C_LIN;
                else
                    vw_reg <= mprod;
            end
            bvcs_pkg::ST_SQ1: t_reg <= mfull;
            bvcs_pkg::ST_SQ2: t_reg <= t_reg + mfull;
            bvcs_pkg::ST_SQRT: if (pend_reg && !sq_busy) dist_reg <= sq_root;
            bvcs_pkg::ST_BASE: b_reg <= used + (bvcs_pkg::ONE_Q - bvcs_pkg::C_APPROACH);
            bvcs_pkg::ST_B2: d_reg <= mprod;
            bvcs_pkg::ST_B3: begin
                if (d_reg > bvcs_pkg::C_DMAX || mprod > bvcs_pkg::C_DMAX)
                    d_reg <= bvcs_pkg::C_DMAX;
                else
                    d_reg <= mprod;
            end
            bvcs_pkg::ST_DX: vx_reg <= mprod;
            bvcs_pkg::ST_DY: vy_reg <= mprod;
            bvcs_pkg::ST_DW: vw_reg <= mprod;
            bvcs_pkg::ST_OUT: m_data_reg <= cand_data;
            default: ;
        endcase
    end

    always_comb begin
        tick_next = (tick_reg < 4'd15) ? tick_reg + 4'd1 : tick_reg;
        if ({27'd0, moved_reg} < bvcs_pkg::C_STALL && tick_next < 4'd15)
            stall_next = (stall_reg < 4'd15) ? stall_reg + 4'd1 : stall_reg;
        else
            stall_next = '0;
    end

    assign st_stuck = stall_next > 4'd10;
    assign cand_data = {2'b0,
        st_stuck && ews_reg, st_stuck, dist_reg < bvcs_pkg::C_ARRIVE,
        (vx_reg <= bvcs_pkg::C_LIN_LIM && vy_reg <= bvcs_pkg::C_LIN_LIM &&
         vw_reg <= bvcs_pkg::C_ANG_LIM),
        enc(nw_reg, vw_reg), enc(ny_reg, vy_reg), enc(nx_reg, vx_reg)};

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
endmodule

/* rtl/bvcs_checker.sv */
// Port-level checks for the base velocity command shaper.
// Bound to base_velocity_command_shaper.
module bvcs_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("beat dropped");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("back-to-back accept");
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[69] |-> m_tdata[68]) else $error("failed without stuck");
endmodule

bind base_velocity_command_shaper bvcs_port_checker u_bvcs_checker (.*);
